// ===== rtl/organized_cloud_normal_map_core_macros.svh =====
// Assertion macros shared by the normal map core RTL.
// Depends on clk and arst_n being visible in the module that expands them.
`ifndef ORGANIZED_CLOUD_NORMAL_MAP_CORE_MACROS_SVH
`define ORGANIZED_CLOUD_NORMAL_MAP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OCNM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define OCNM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define OCNM_ASSERT_IMP(label, ante, cons, msg)
`define OCNM_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

// ===== rtl/ocnm_pkg.sv =====
// Types, constants and state codes for the organized cloud normal map core.
// No dependencies.
`timescale 1ns / 1ps
package ocnm_pkg;

	localparam int CFG_W          = 11;
	localparam int CFG_ADDR_W     = 1;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int MIN_SIZE       = 3;
	localparam int QUEUE_DEPTH    = 2;
	localparam int ROOT_STEPS     = 25;
	localparam int DIV_STEPS      = 15;

	localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] CFG_FRAME_HEIGHT = 1'b1;

	localparam logic signed [15:0] ONE_FX = 16'sd16384;

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic signed [15:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic               last_of_run;
		logic               end_of_frame;
	} result_t;

	typedef struct packed {
		logic has_norm;
		logic interior;
		logic norm_last;
		logic has_border;
		logic frame_end;
	} flags_t;

	typedef struct packed {
		point_t up;
		point_t dn;
		point_t lf;
		point_t rt;
		flags_t flags;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RD0,
		F_RD1,
		F_WR
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_CROSS,
		B_NORM,
		B_SQUARE,
		B_ROOT,
		B_DSETUP,
		B_DIV,
		B_FIN,
		B_EMIT_N,
		B_EMIT_B
	} back_state_t;

endpackage

// ===== rtl/ocnm_fifo.sv =====
// Short job queue between the front and the back of the normal map core.
// Depends on ocnm_pkg for the job type.
`timescale 1ns / 1ps
module ocnm_fifo #(
	parameter int DEPTH = ocnm_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ocnm_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output ocnm_pkg::job_t pop_data,
	output logic           empty
);
	import ocnm_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	job_t           mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [NW-1:0]  count_q;

	assign full     = (count_q == NW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/ocnm_front.sv =====
// Front of the normal map core: takes points, tracks the raster position,
// keeps the two line buffers, queues a job per point past row 0; uses ocnm_pkg.
`timescale 1ns / 1ps
`include "organized_cloud_normal_map_core_macros.svh"
module ocnm_front #(
	parameter int MAX_WIDTH  = ocnm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ocnm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  ocnm_pkg::point_t           in_data,
	input  logic [ocnm_pkg::CFG_W-1:0] frame_width,
	input  logic [ocnm_pkg::CFG_W-1:0] frame_height,
	input  logic                       q_full,
	output logic                       push,
	output ocnm_pkg::job_t             push_data
);
	import ocnm_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int RW  = $clog2(MAX_HEIGHT);
	localparam int WSZ = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
	localparam int HSZ = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

	front_state_t  state_q, state_d;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [CW-1:0] c_q;
	point_t        p_q, old_q, prev_mid_q;
	flags_t        flags_q;

	point_t        older_mem [MAX_WIDTH];
	point_t        newer_mem [MAX_WIDTH];
	point_t        older_rd, newer_rd;

	logic          accept;
	logic          rd_old_en, rd_new_en, wr_en;
	logic [CW-1:0] rd_addr;

	// effective frame size
	logic [WSZ-1:0] fw_ext;
	logic [HSZ-1:0] fh_ext;
	logic [CW:0]    w_eff, w_last_ext;
	logic [RW:0]    h_eff, h_last_ext;
	logic [CW-1:0]  w_last, c;
	logic [RW-1:0]  h_last, r;
	logic           last_col, last_row;
	flags_t         flags_d;

	assign fw_ext = WSZ'(frame_width);
	assign fh_ext = HSZ'(frame_height);

	always_comb begin
		if (fw_ext < WSZ'(MIN_SIZE)) w_eff = (CW + 1)'(MIN_SIZE);
		else if (fw_ext > WSZ'(MAX_WIDTH)) w_eff = (CW + 1)'(MAX_WIDTH);
		else w_eff = fw_ext[CW:0];
		if (fh_ext < HSZ'(MIN_SIZE)) h_eff = (RW + 1)'(MIN_SIZE);
		else if (fh_ext > HSZ'(MAX_HEIGHT)) h_eff = (RW + 1)'(MAX_HEIGHT);
		else h_eff = fh_ext[RW:0];
	end

	assign w_last_ext = w_eff - 1'b1;
	assign h_last_ext = h_eff - 1'b1;
	assign w_last     = w_last_ext[CW-1:0];
	assign h_last     = h_last_ext[RW-1:0];
	// clamp a position left beyond a shrunk frame
	assign c          = (col_q < w_last) ? col_q : w_last;
	assign r          = (row_q < h_last) ? row_q : h_last;
	assign last_col   = (c == w_last);
	assign last_row   = (r == h_last);

	always_comb begin
		flags_d.has_norm   = (r != '0);
		flags_d.interior   = (c != '0) && !last_col && (r > RW'(1));
		flags_d.norm_last  = !last_row;
		flags_d.has_border = last_row;
		flags_d.frame_end  = last_col;
	end

	assign accept = in_valid & in_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: if (accept) state_d = F_RD0;
			F_RD0:  state_d = F_RD1;
			F_RD1:  state_d = F_WR;
			F_WR:   state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		rd_old_en = 1'b0;
		rd_new_en = 1'b0;
		wr_en     = 1'b0;
		push      = 1'b0;
		rd_addr   = c_q;
		unique case (state_q)
			F_IDLE: in_ready = !q_full;
			F_RD0: begin
				rd_old_en = 1'b1;
				rd_new_en = 1'b1;
			end
			F_RD1: begin
				rd_new_en = 1'b1;
				rd_addr   = c_q + 1'b1;
			end
			F_WR: begin
				wr_en = 1'b1;
				push  = flags_q.has_norm | flags_q.has_border;
			end
			default: in_ready = 1'b0;
		endcase
	end

	always_comb begin
		push_data.up    = older_rd;
		push_data.dn    = p_q;
		push_data.lf    = prev_mid_q;
		push_data.rt    = newer_rd;
		push_data.flags = flags_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) older_mem[c_q] <= old_q;
		if (rd_old_en) older_rd <= older_mem[c_q];
	end

	always_ff @(posedge clk) begin
		if (wr_en) newer_mem[c_q] <= p_q;
		if (rd_new_en) newer_rd <= newer_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q     <= in_data;
			c_q     <= c;
			flags_q <= flags_d;
		end
		if (state_q == F_RD1) old_q <= newer_rd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= F_IDLE;
			col_q      <= '0;
			row_q      <= '0;
			prev_mid_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : r + 1'b1;
				end else begin
					col_q <= c + 1'b1;
					row_q <= r;
				end
			end
			if (state_q == F_WR) prev_mid_q <= old_q;
		end
	end

	`OCNM_ASSERT_IMP(a_push_space, push, !q_full, "job pushed into a full queue")
	`OCNM_ASSERT_NXT(a_one_in_flight, accept, !in_ready, "second point taken while busy")
	`OCNM_ASSERT_IMP(a_fixed_latency, accept, ##4 (state_q == F_IDLE), "front did not return")

endmodule

// ===== rtl/ocnm_back.sv =====
// Back of the normal map core: for an interior job cross product, normalize,
// square root and three-lane division, then result register. Uses ocnm_pkg.
`timescale 1ns / 1ps
`include "organized_cloud_normal_map_core_macros.svh"
module ocnm_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  ocnm_pkg::job_t    q_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output ocnm_pkg::result_t out_data
);
	import ocnm_pkg::*;

	back_state_t        state_q, state_d;
	logic [4:0]         step_q;
	job_t               job_q;
	logic [2:0]         cs_q;
	logic [33:0]        m_q [3];
	logic [49:0]        acc_q;
	logic [27:0]        rem_q;
	logic [24:0]        root_q;
	logic [24:0]        drem_q [3];
	logic [14:0]        dlow_q [3];
	logic [14:0]        quo_q [3];
	logic signed [15:0] n_q [3];
	logic               out_valid_q;
	result_t            out_data_q;

	logic    slot_free, load;
	result_t load_data;

	// edge vectors
	logic signed [16:0] ax, ay, az, bx, by, bz;
	assign ax = {job_q.rt.point_x[15], job_q.rt.point_x} - {job_q.lf.point_x[15], job_q.lf.point_x};
	assign ay = {job_q.rt.point_y[15], job_q.rt.point_y} - {job_q.lf.point_y[15], job_q.lf.point_y};
	assign az = {job_q.rt.point_z[15], job_q.rt.point_z} - {job_q.lf.point_z[15], job_q.lf.point_z};
	assign bx = {job_q.up.point_x[15], job_q.up.point_x} - {job_q.dn.point_x[15], job_q.dn.point_x};
	assign by = {job_q.up.point_y[15], job_q.up.point_y} - {job_q.dn.point_y[15], job_q.dn.point_y};
	assign bz = {job_q.up.point_z[15], job_q.up.point_z} - {job_q.dn.point_z[15], job_q.dn.point_z};

	// one cross product component per cycle
	logic signed [16:0] op1a, op1b, op2a, op2b;
	logic signed [33:0] prod1, prod2;
	logic [34:0]        cdiff, cabs;

	always_comb begin
		unique case (step_q[1:0])
			2'd0: begin op1a = ay; op1b = bz; op2a = az; op2b = by; end
			2'd1: begin op1a = az; op1b = bx; op2a = ax; op2b = bz; end
			2'd2: begin op1a = ax; op1b = by; op2a = ay; op2b = bx; end
			default: begin op1a = '0; op1b = '0; op2a = '0; op2b = '0; end
		endcase
	end

	assign prod1 = op1a * op1b;
	assign prod2 = op2a * op2b;
	assign cdiff = {prod1[33], prod1} - {prod2[33], prod2};
	assign cabs  = cdiff[34] ? (~cdiff + 1'b1) : cdiff;

	// largest magnitude steers the normalizing shift
	logic [33:0] mx01, mx;
	logic        norm_zero, norm_done;
	assign mx01      = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
	assign mx        = (mx01 > m_q[2]) ? mx01 : m_q[2];
	assign norm_zero = (mx == '0);
	assign norm_done = (mx[33:24] == '0) && mx[23];

	logic [33:0] m_sel;
	logic [47:0] sq;
	assign m_sel = m_q[step_q[1:0]];
	assign sq    = m_sel[23:0] * m_sel[23:0];

	// square root digit
	logic [27:0] rem_sh, trial;
	logic        root_ge;
	assign rem_sh  = {rem_q[25:0], acc_q[49:48]};
	assign trial   = {1'b0, root_q, 2'b01};
	assign root_ge = (rem_sh >= trial);

	// division lanes
	logic [25:0] dt [3];
	logic [25:0] dsub [3];
	logic        dge [3];
	logic [38:0] num [3];
	logic [14:0] qcl [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dt[i]   = {drem_q[i], dlow_q[i][14]};
			dge[i]  = (dt[i] >= {1'b0, root_q});
			dsub[i] = dt[i] - {1'b0, root_q};
			num[i]  = {1'b0, m_q[i][23:0], 14'b0} + 39'(root_q >> 1);
			qcl[i]  = (quo_q[i] > 15'd16384) ? 15'd16384 : quo_q[i];
		end
	end

	assign slot_free = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (!q_empty) begin
					if (!q_data.flags.has_norm) state_d = B_EMIT_B;
					else if (q_data.flags.interior) state_d = B_CROSS;
					else state_d = B_EMIT_N;
				end
			end
			B_CROSS:  if (step_q == 5'd2) state_d = B_NORM;
			B_NORM: begin
				if (norm_zero) state_d = B_EMIT_N;
				else if (norm_done) state_d = B_SQUARE;
			end
			B_SQUARE: if (step_q == 5'd2) state_d = B_ROOT;
			B_ROOT:   if (step_q == 5'(ROOT_STEPS - 1)) state_d = B_DSETUP;
			B_DSETUP: state_d = B_DIV;
			B_DIV:    if (step_q == 5'(DIV_STEPS - 1)) state_d = B_FIN;
			B_FIN:    state_d = B_EMIT_N;
			B_EMIT_N: if (slot_free) state_d = job_q.flags.has_border ? B_EMIT_B : B_IDLE;
			B_EMIT_B: if (slot_free) state_d = B_IDLE;
			default:  state_d = B_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		load_data = '{normal_x: '0, normal_y: '0, normal_z: ONE_FX,
			last_of_run: 1'b1, end_of_frame: job_q.flags.frame_end};
		unique case (state_q)
			B_IDLE: pop = !q_empty;
			B_EMIT_N: begin
				load      = slot_free;
				load_data = '{normal_x: n_q[0], normal_y: n_q[1], normal_z: n_q[2],
					last_of_run: job_q.flags.norm_last, end_of_frame: 1'b0};
			end
			B_EMIT_B: load = slot_free;
			default: pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				job_q <= q_data;
				n_q[0] <= '0;
				n_q[1] <= '0;
				n_q[2] <= ONE_FX;
			end
			B_CROSS: begin
				cs_q[step_q[1:0]] <= cdiff[34];
				m_q[step_q[1:0]]  <= cabs[33:0];
				acc_q             <= '0;
			end
			B_NORM: begin
				for (int i = 0; i < 3; i++) begin
					priority if (mx[33:28] != '0) m_q[i] <= m_q[i] >> 4;
					else if (mx[33:24] != '0) m_q[i] <= m_q[i] >> 1;
					else if (mx[33:15] == '0) m_q[i] <= m_q[i] << 8;
					else if (mx[33:19] == '0) m_q[i] <= m_q[i] << 4;
					else if (mx[33:23] == '0) m_q[i] <= m_q[i] << 1;
					else m_q[i] <= m_q[i];
				end
				rem_q  <= '0;
				root_q <= '0;
			end
			B_SQUARE: acc_q <= acc_q + 50'(sq);
			B_ROOT: begin
				acc_q  <= acc_q << 2;
				rem_q  <= root_ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[23:0], root_ge};
			end
			B_DSETUP: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= {1'b0, num[i][38:15]};
					dlow_q[i] <= num[i][14:0];
					quo_q[i]  <= '0;
				end
			end
			B_DIV: begin
				for (int i = 0; i < 3; i++) begin
					drem_q[i] <= dge[i] ? dsub[i][24:0] : dt[i][24:0];
					dlow_q[i] <= dlow_q[i] << 1;
					quo_q[i]  <= {quo_q[i][13:0], dge[i]};
				end
			end
			B_FIN: begin
				for (int i = 0; i < 3; i++)
					n_q[i] <= cs_q[i] ? -$signed({1'b0, qcl[i]}) : $signed({1'b0, qcl[i]});
			end
			default: acc_q <= acc_q;
		endcase
		if (load) out_data_q <= load_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`OCNM_ASSERT_IMP(a_norm_range, state_q == B_SQUARE, norm_done, "magnitudes not normalized")
	`OCNM_ASSERT_IMP(a_root_floor, state_q == B_DSETUP, root_q[24] || root_q[23], "length too small")
	`OCNM_ASSERT_IMP(a_load_free, load, !out_valid_q || out_ready, "result overwrote a held beat")

endmodule

// ===== rtl/organized_cloud_normal_map_core.sv =====
// Channel | Dir | Handshake          | Beat
// cfg     | in  | cfg_we             | cfg_addr register index, cfg_wdata value
// in      | in  | in_valid/in_ready  | in_data: point_x, point_y, point_z
// out     | out | out_valid/out_ready| out_data: normal_x/y/z, last_of_run, end_of_frame
// The front takes one point at a time: accept, then the states F_RD0, F_RD1, F_WR.
// Each interior normal runs the back in order: pop, cross product, normalize (a zero
// vector skips to emit), square, square root, divide setup, divide, finish and emit;
// the root and divide loops set the sustained rate. Other jobs emit after the pop.
// Reset clears position counters and loads 640 x 480; line buffers are not cleared.
// A full queue stalls the front; a held output beat stalls the back.
// Top level of the organized cloud normal map core; config registers and wiring.
// Depends on ocnm_pkg, ocnm_front, ocnm_fifo and ocnm_back.
`timescale 1ns / 1ps
module organized_cloud_normal_map_core #(
	parameter int MAX_WIDTH  = ocnm_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ocnm_pkg::DEF_MAX_HEIGHT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ocnm_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ocnm_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  ocnm_pkg::point_t                in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output ocnm_pkg::result_t               out_data
);
	import ocnm_pkg::*;

	logic [CFG_W-1:0] width_q, height_q;
	logic             q_push, q_pop, q_full, q_empty;
	job_t             q_in, q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FRAME_WIDTH:  width_q  <= cfg_wdata;
				CFG_FRAME_HEIGHT: height_q <= cfg_wdata;
				default:          width_q  <= width_q;
			endcase
		end
	end

	ocnm_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.frame_width (width_q),
		.frame_height(height_q),
		.q_full      (q_full),
		.push        (q_push),
		.push_data   (q_in)
	);

	ocnm_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_out),
		.empty    (q_empty)
	);

	ocnm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (q_out),
		.pop      (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule
